@@ hdl/sfla_pkg.sv @@
`default_nettype none

package sfla_pkg;

  // Fixed field widths of the request, result and configuration ports
  localparam int unsigned CfgClasses = 4;
  localparam int unsigned ClassW     = 2;
  localparam int unsigned OpW        = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned ReqW       = 16;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned SlotBytesW = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  // Defaults for the top-level parameters
  localparam int unsigned DefNumClasses   = 4;
  localparam int unsigned DefRegionBytes  = 65536;
  localparam int unsigned DefGranuleBytes = 16;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_INIT_OVF  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOT_BYTES0 = 3'd0,
    CFG_SLOT_BYTES1 = 3'd1,
    CFG_SLOT_BYTES2 = 3'd2,
    CFG_SLOT_BYTES3 = 3'd3,
    CFG_SLOTS0      = 3'd4,
    CFG_SLOTS1      = 3'd5,
    CFG_SLOTS2      = 3'd6,
    CFG_SLOTS3      = 3'd7
  } cfg_reg_e;

  typedef logic [SlotBytesW-1:0] slot_bytes_t;

  // Reset slot sizes of the classes
  localparam slot_bytes_t SlotBytesReset [CfgClasses] = '{
    16'd16, 16'd32, 16'd256, 16'd1024
  };

  // Class lookup result
  typedef struct packed {
    logic              hit;
    logic [ClassW-1:0] cls;
  } class_pick_t;

endpackage

`default_nettype wire

@@ hdl/sfla_link_mem.sv @@
`default_nettype none

module sfla_link_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 13
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, read data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/sfla_class_pick.sv @@
`default_nettype none

module sfla_class_pick #(
  parameter int unsigned NUM_CLASSES = sfla_pkg::DefNumClasses
) (
  input  wire logic [sfla_pkg::ReqW-1:0]                               req_bytes_i,
  input  wire logic [sfla_pkg::CfgClasses-1:0][sfla_pkg::SlotBytesW-1:0] slot_bytes_i,
  output      sfla_pkg::class_pick_t                                   pick_o
);

  import sfla_pkg::*;

  localparam int unsigned Active = (NUM_CLASSES < CfgClasses) ? NUM_CLASSES : CfgClasses;

  // Lowest active class whose slot covers the size; walk down so the lowest wins
  always_comb begin
    pick_o = '0;
    for (int c = int'(Active) - 1; c >= 0; c--) begin
      if (req_bytes_i <= slot_bytes_i[c]) begin
        pick_o.hit = 1'b1;
        pick_o.cls = ClassW'(c);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/segregated_free_list_allocator_top.sv @@
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    operation_i, request_bytes_i, free_address_i
// result    out        out_valid_o / out_stall_i  status_o, address_o, size_class_o
// config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// Allocate, free and unknown operations go from idle to the finish step, which loads the
// result register once it is free and returns to idle; the link memory read of the list
// head is started on accept and its registered data is used in the finish step.
// Init steps through size, need, check, link and next per active class, then finishes.
// Reset (rst_ni low) empties all lists and restores the slot registers; link memory
// keeps no reset. A stalled result waits in the output register; a new request is
// accepted meanwhile and finishes once that register frees up.
`default_nettype none

module segregated_free_list_allocator_top #(
  parameter int unsigned NUM_CLASSES   = sfla_pkg::DefNumClasses,
  parameter int unsigned REGION_BYTES  = sfla_pkg::DefRegionBytes,
  parameter int unsigned GRANULE_BYTES = sfla_pkg::DefGranuleBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [sfla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sfla_pkg::CfgDataW-1:0] cfg_data_i,
  // request
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [sfla_pkg::OpW-1:0]      operation_i,
  input  wire logic [sfla_pkg::ReqW-1:0]     request_bytes_i,
  input  wire logic [sfla_pkg::AddrW-1:0]    free_address_i,
  // result
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [sfla_pkg::StatusW-1:0]  status_o,
  output      logic [sfla_pkg::AddrW-1:0]    address_o,
  output      logic [sfla_pkg::ClassW-1:0]   size_class_o
);

  import sfla_pkg::*;

  localparam int unsigned Granules = REGION_BYTES / GRANULE_BYTES;
  localparam int unsigned LinkW    = $clog2(Granules + 1);
  localparam int unsigned IdxW     = $clog2(Granules);
  localparam int unsigned Active   = (NUM_CLASSES < CfgClasses) ? NUM_CLASSES : CfgClasses;
  localparam logic [LinkW-1:0] Empty = LinkW'(Granules);
  localparam logic [ClassW-1:0] LastClass = ClassW'(Active - 1);

  // Division by the granule size as multiply by reciprocal and shift
  localparam int unsigned GranL     = $clog2(GRANULE_BYTES);
  localparam int unsigned FaShift   = ReqW + GranL;
  localparam int unsigned FaMul     = ((1 << FaShift) + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int unsigned FaMulW    = ReqW + 1;
  localparam int unsigned FaQW      = $clog2(((1 << ReqW) - 1) / GRANULE_BYTES + 1);
  localparam int unsigned CeilW     = SlotBytesW + 1;
  localparam int unsigned CeilShift = CeilW + GranL;
  localparam int unsigned CeilMul   = ((1 << CeilShift) + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int unsigned CeilMulW  = CeilW + 1;
  localparam int unsigned GszW      = $clog2(((1 << SlotBytesW) - 1 + GRANULE_BYTES - 1)
                                             / GRANULE_BYTES + 1);
  localparam int unsigned NeedW     = GszW + CountW;
  localparam int unsigned SumW      = ((NeedW > LinkW) ? NeedW : LinkW) + 1;

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_FINISH     = 7'b0000010,
    S_INIT_SIZE  = 7'b0000100,
    S_INIT_NEED  = 7'b0001000,
    S_INIT_CHECK = 7'b0010000,
    S_INIT_LINK  = 7'b0100000,
    S_INIT_NEXT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CfgClasses-1:0][SlotBytesW-1:0] slot_bytes_q;
  logic [CfgClasses-1:0][CountW-1:0]     slots_q;

  // list state
  logic [LinkW-1:0] heads_q [CfgClasses];
  logic [LinkW-1:0] heads_d [CfgClasses];
  logic [LinkW-1:0] used_q, used_d;

  // per-request registers
  op_e               op_q, op_d;
  logic              hit_q, hit_d;
  logic [ClassW-1:0] cls_q, cls_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic [FaQW-1:0]   g_q, g_d;

  // init walk registers
  logic [ClassW-1:0] c_q, c_d;
  logic [GszW-1:0]   gsz_q, gsz_d;
  logic [CountW-1:0] n_q, n_d;
  logic [NeedW-1:0]  need_q, need_d;
  logic [LinkW-1:0]  here_q, here_d;
  logic [CountW-1:0] k_q, k_d;
  logic              ovf_q, ovf_d;

  // result register
  logic              out_valid_q, out_valid_d;
  status_e           res_status_q, res_status_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic [ClassW-1:0] res_cls_q, res_cls_d;

  // link memory port
  logic             mem_en, mem_we;
  logic [IdxW-1:0]  mem_addr;
  logic [LinkW-1:0] mem_wdata, mem_rdata;

  class_pick_t                pick;
  logic [LinkW-1:0]           head_sel;
  logic [ReqW+FaMulW-1:0]     fa_prod;
  logic [CeilW-1:0]           ceil_in;
  logic [CeilW+CeilMulW-1:0]  ceil_prod;
  logic                       fits;
  logic                       last_slot;
  logic                       accept;
  logic                       res_free;

  sfla_class_pick #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_class_pick (
    .req_bytes_i  (request_bytes_i),
    .slot_bytes_i (slot_bytes_q),
    .pick_o       (pick)
  );

  sfla_link_mem #(
    .DEPTH (Granules),
    .WIDTH (LinkW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign res_free   = !out_valid_q || !out_stall_i;
  assign head_sel   = heads_q[pick.cls];

  // granule index of the freed offset, and slot size in granules (rounded up)
  assign fa_prod   = (ReqW + FaMulW)'(free_address_i) * (ReqW + FaMulW)'(FaMul);
  assign ceil_in   = CeilW'(slot_bytes_q[c_q]) + CeilW'(GRANULE_BYTES - 1);
  assign ceil_prod = (CeilW + CeilMulW)'(ceil_in) * (CeilW + CeilMulW)'(CeilMul);

  assign fits      = (SumW'(used_q) + SumW'(need_q)) <= SumW'(Granules);
  assign last_slot = ((CountW + 1)'(k_q) + (CountW + 1)'(1)) == (CountW + 1)'(n_q);

  // next-state logic
  always_comb begin
    state_d      = state_q;
    heads_d      = heads_q;
    used_d       = used_q;
    op_d         = op_q;
    hit_d        = hit_q;
    cls_d        = cls_q;
    head_d       = head_q;
    g_d          = g_q;
    c_d          = c_q;
    gsz_d        = gsz_q;
    n_d          = n_q;
    need_d       = need_q;
    here_d       = here_q;
    k_d          = k_q;
    ovf_d        = ovf_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_cls_d    = res_cls_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;

    case (state_q)
      // take a request, look up class and head, start the head's link read for an allocation
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_e'(operation_i);
          hit_d  = pick.hit;
          cls_d  = pick.cls;
          head_d = head_sel;
          g_d    = fa_prod[FaShift +: FaQW];
          case (op_e'(operation_i))
            OP_ALLOC: begin
              if (pick.hit && (head_sel < Empty)) begin
                mem_en   = 1'b1;
                mem_addr = IdxW'(head_sel);
              end
              state_d = S_FINISH;
            end
            OP_INIT: begin
              used_d = '0;
              for (int c = 0; c < CfgClasses; c++) begin
                heads_d[c] = Empty;
              end
              c_d     = '0;
              ovf_d   = 1'b0;
              state_d = S_INIT_SIZE;
            end
            default: state_d = S_FINISH;
          endcase
        end
      end

      // commit list update and load the result register
      S_FINISH: begin
        if (res_free) begin
          out_valid_d  = 1'b1;
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_cls_d    = '0;
          state_d      = S_IDLE;
          case (op_q)
            OP_ALLOC: begin
              if (!hit_q) begin
                res_status_d = ST_TOO_LARGE;
              end else if (head_q >= Empty) begin
                res_status_d = ST_EXHAUSTED;
                res_cls_d    = cls_q;
              end else begin
                heads_d[cls_q] = mem_rdata;
                res_addr_d     = AddrW'(32'(head_q) * GRANULE_BYTES);
                res_cls_d      = cls_q;
              end
            end
            OP_FREE: begin
              if (!hit_q) begin
                res_status_d = ST_TOO_LARGE;
              end else if (32'(g_q) >= Granules) begin
                res_status_d = ST_TOO_LARGE;
                res_cls_d    = cls_q;
              end else begin
                mem_en         = 1'b1;
                mem_we         = 1'b1;
                mem_addr       = IdxW'(g_q);
                mem_wdata      = head_q;
                heads_d[cls_q] = LinkW'(g_q);
                res_addr_d     = AddrW'(32'(g_q) * GRANULE_BYTES);
                res_cls_d      = cls_q;
              end
            end
            OP_INIT: begin
              if (ovf_q) begin
                res_status_d = ST_INIT_OVF;
              end
            end
            default: ;
          endcase
        end
      end

      // slot size in granules and slot count of the current class
      S_INIT_SIZE: begin
        gsz_d   = ceil_prod[CeilShift +: GszW];
        n_d     = slots_q[c_q];
        state_d = S_INIT_NEED;
      end

      S_INIT_NEED: begin
        need_d  = NeedW'(gsz_q) * NeedW'(n_q);
        state_d = S_INIT_CHECK;
      end

      // skip empty classes, flag classes that do not fit, start carving the others
      S_INIT_CHECK: begin
        if ((gsz_q == '0) || (n_q == '0)) begin
          state_d = S_INIT_NEXT;
        end else if (!fits) begin
          ovf_d   = 1'b1;
          state_d = S_INIT_NEXT;
        end else begin
          here_d  = used_q;
          k_d     = '0;
          state_d = S_INIT_LINK;
        end
      end

      // chain one slot per cycle
      S_INIT_LINK: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = IdxW'(here_q);
        mem_wdata = last_slot ? Empty : (here_q + LinkW'(gsz_q));
        if (last_slot) begin
          heads_d[c_q] = used_q;
          used_d       = LinkW'(SumW'(used_q) + SumW'(need_q));
          state_d      = S_INIT_NEXT;
        end else begin
          here_d = here_q + LinkW'(gsz_q);
          k_d    = k_q + CountW'(1);
        end
      end

      S_INIT_NEXT: begin
        if (c_q == LastClass) begin
          state_d = S_FINISH;
        end else begin
          c_d     = c_q + ClassW'(1);
          state_d = S_INIT_SIZE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      for (int c = 0; c < CfgClasses; c++) begin
        heads_q[c] <= Empty;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      heads_q     <= heads_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CfgClasses; c++) begin
        slot_bytes_q[c] <= SlotBytesReset[c];
        slots_q[c]      <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SLOT_BYTES0: slot_bytes_q[0] <= cfg_data_i;
        CFG_SLOT_BYTES1: slot_bytes_q[1] <= cfg_data_i;
        CFG_SLOT_BYTES2: slot_bytes_q[2] <= cfg_data_i;
        CFG_SLOT_BYTES3: slot_bytes_q[3] <= cfg_data_i;
        CFG_SLOTS0:      slots_q[0]      <= cfg_data_i[CountW-1:0];
        CFG_SLOTS1:      slots_q[1]      <= cfg_data_i[CountW-1:0];
        CFG_SLOTS2:      slots_q[2]      <= cfg_data_i[CountW-1:0];
        CFG_SLOTS3:      slots_q[3]      <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    hit_q        <= hit_d;
    cls_q        <= cls_d;
    head_q       <= head_d;
    g_q          <= g_d;
    c_q          <= c_d;
    gsz_q        <= gsz_d;
    n_q          <= n_d;
    need_q       <= need_d;
    here_q       <= here_d;
    k_q          <= k_d;
    ovf_q        <= ovf_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_cls_q    <= res_cls_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_status_q;
  assign address_o    = res_addr_q;
  assign size_class_o = res_cls_q;

  // non-init requests go straight to the finish step
  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i != OP_INIT)) |=> (state_q == S_FINISH))
    else $error("request did not reach finish step");

  // result register only fills from the finish step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result appeared outside finish step");

  // carving never writes past the region
  a_link_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT_LINK) |-> (here_q < Empty))
    else $error("init link write beyond region");

  // carved granules never exceed the region
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Empty)
    else $error("used granules beyond region");

endmodule

`default_nettype wire
